// ===== rtl/core/ddsosc_pkg.sv =====
package ddsosc_pkg;

  // quarter-wave table size, a power of two
  localparam int SINE_DEPTH = 1024;
  localparam int ROM_AW     = $clog2(SINE_DEPTH + 1);
  localparam int IDX_W      = $clog2(4 * SINE_DEPTH);

  // fixed-point constants
  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [15:0] DIST_ONE    = 16'd4096;
  localparam logic [15:0] PAN_ONE     = 16'd32768;
  localparam logic [15:0] AMP_RESET   = 16'd32768;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_BASE_INC  = 3'd0,
    REG_HZ_GAIN   = 3'd1,
    REG_AMPLITUDE = 3'd2,
    REG_FM_EN     = 3'd3,
    REG_SPATIAL   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [23:0] freq_offset;
    logic [15:0]        distance_gain;
    logic [15:0]        pan_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample_first;
    logic signed [15:0] sample_other;
  } out_item_t;

  typedef struct packed {
    logic [31:0] base_increment;
    logic [31:0] hz_to_phase_gain;
    logic [15:0] amplitude;
    logic        fm_enable;
    logic        spatial_enable;
  } cfg_t;

  // shared multiplier operand selection
  typedef enum logic [2:0] {
    MUL_NONE   = 3'd0,
    MUL_FM     = 3'd1,
    MUL_SQ     = 3'd2,
    MUL_AMP    = 3'd3,
    MUL_DIST_A = 3'd4,
    MUL_DIST_B = 3'd5,
    MUL_OUT_A  = 3'd6,
    MUL_OUT_B  = 3'd7
  } mul_sel_t;

  // sine table lookup phase selection
  typedef enum logic [1:0] {
    ROM_ANG   = 2'd0,
    ROM_ANG_Q = 2'd1,
    ROM_PHASE = 2'd2
  } rom_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     phase_upd;
    logic     pan_a_ld;
    logic     pan_b_ld;
    logic     sign_ld;
    logic     p1_ld;
    logic     qa_ld;
    logic     qb_ld;
    logic     res_a_ld;
    logic     out_ld;
    mul_sel_t mul_sel;
    rom_sel_t rom_sel;
  } cmd_t;

  typedef logic [SINE_DEPTH:0][15:0] sine_rom_t;

  // quarter-wave sine table in Q1.15, integer Taylor series in Q30
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    for (int k = 0; k <= SINE_DEPTH; k++) begin
      x  = (64'(k) * HALF_PI_Q30 + 64'(SINE_DEPTH / 2)) / 64'(SINE_DEPTH);
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd156;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      rom[k] = 16'((s * 64'd32767 + (64'd1 << 29)) >> 30);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ===== rtl/core/ddsosc_regs.sv =====
module ddsosc_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  output ddsosc_pkg::cfg_t   cfg
);

  ddsosc_pkg::cfg_t cfg_r;
  ddsosc_pkg::cfg_t cfg_nxt;

  // register write decode, unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        ddsosc_pkg::REG_BASE_INC:  cfg_nxt.base_increment   = cfg_wdata;
        ddsosc_pkg::REG_HZ_GAIN:   cfg_nxt.hz_to_phase_gain = cfg_wdata;
        ddsosc_pkg::REG_AMPLITUDE: cfg_nxt.amplitude        = cfg_wdata[15:0];
        ddsosc_pkg::REG_FM_EN:     cfg_nxt.fm_enable        = cfg_wdata[0];
        ddsosc_pkg::REG_SPATIAL:   cfg_nxt.spatial_enable   = cfg_wdata[0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_increment   <= '0;
      cfg_r.hz_to_phase_gain <= '0;
      cfg_r.amplitude        <= ddsosc_pkg::AMP_RESET;
      cfg_r.fm_enable        <= 1'b0;
      cfg_r.spatial_enable   <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/ddsosc_ctrl.sv =====
module ddsosc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               out_ready,
  output logic               out_valid,
  output ddsosc_pkg::cmd_t   cmd
);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_FM   = 10'b00_0000_0010,
    ST_PH   = 10'b00_0000_0100,
    ST_PA   = 10'b00_0000_1000,
    ST_PB   = 10'b00_0001_0000,
    ST_DA   = 10'b00_0010_0000,
    ST_DB   = 10'b00_0100_0000,
    ST_OA   = 10'b00_1000_0000,
    ST_OB   = 10'b01_0000_0000,
    ST_DONE = 10'b10_0000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  // sequencer: at most one multiply and one table read per step
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.mul_sel   = ddsosc_pkg::MUL_NONE;
    cmd.rom_sel   = ddsosc_pkg::ROM_PHASE;
    case (state_r)
      ST_IDLE: begin
        cmd.load_in = in_valid;
        if (in_valid) begin
          state_nxt = ST_FM;
        end
      end
      ST_FM: begin
        cmd.mul_sel = ddsosc_pkg::MUL_FM;
        cmd.rom_sel = ddsosc_pkg::ROM_ANG;
        state_nxt   = ST_PH;
      end
      ST_PH: begin
        cmd.phase_upd = 1'b1;
        cmd.mul_sel   = ddsosc_pkg::MUL_SQ;
        cmd.rom_sel   = ddsosc_pkg::ROM_ANG_Q;
        state_nxt     = ST_PA;
      end
      ST_PA: begin
        cmd.pan_a_ld = 1'b1;
        cmd.mul_sel  = ddsosc_pkg::MUL_SQ;
        cmd.rom_sel  = ddsosc_pkg::ROM_PHASE;
        state_nxt    = ST_PB;
      end
      ST_PB: begin
        cmd.pan_b_ld = 1'b1;
        cmd.sign_ld  = 1'b1;
        cmd.mul_sel  = ddsosc_pkg::MUL_AMP;
        state_nxt    = ST_DA;
      end
      ST_DA: begin
        cmd.p1_ld   = 1'b1;
        cmd.mul_sel = ddsosc_pkg::MUL_DIST_A;
        state_nxt   = ST_DB;
      end
      ST_DB: begin
        cmd.qa_ld   = 1'b1;
        cmd.mul_sel = ddsosc_pkg::MUL_DIST_B;
        state_nxt   = ST_OA;
      end
      ST_OA: begin
        cmd.qb_ld   = 1'b1;
        cmd.mul_sel = ddsosc_pkg::MUL_OUT_A;
        state_nxt   = ST_OB;
      end
      ST_OB: begin
        cmd.res_a_ld = 1'b1;
        cmd.mul_sel  = ddsosc_pkg::MUL_OUT_B;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        // wait here while the output register still holds a transaction
        if (!out_valid_r || out_ready) begin
          cmd.out_ld = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/core/ddsosc_dp.sv =====
module ddsosc_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ddsosc_pkg::cfg_t       cfg,
  input  ddsosc_pkg::cmd_t       cmd,
  input  ddsosc_pkg::in_item_t   in_data,
  output ddsosc_pkg::out_item_t  out_data
);

  localparam int AW = ddsosc_pkg::ROM_AW;
  localparam int IW = ddsosc_pkg::IDX_W;

  logic        freq_neg_r;
  logic [23:0] freq_mag_r;
  logic [15:0] dist_r;
  logic [15:0] ang_r;
  logic [31:0] phase_r;
  logic [31:0] phase_nxt;
  logic [63:0] prod_r;
  logic [15:0] pan_a_r;
  logic [15:0] pan_b_r;
  logic        sign_r;
  logic [31:0] p1_r;
  logic [31:0] qa_r;
  logic [31:0] qb_r;
  logic [15:0] res_a_r;
  logic [15:0] rom_q_r;
  logic        rom_neg_r;
  ddsosc_pkg::out_item_t out_data_r;

  logic [23:0] freq_raw;
  logic [31:0] lookup_ph;
  logic [IW-1:0] lookup_idx;
  logic [1:0]  lookup_quad;
  logic [AW-1:0] lookup_off;
  logic [AW-1:0] rom_addr;
  logic [47:0] prod_neg;
  logic [31:0] step_offset;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [15:0] pan_val;
  logic [15:0] res_b;

  // round half away from zero, reapply sign, clip to 16 bits
  function automatic logic [15:0] round_sat(input logic [63:0] p, input logic neg);
    logic [63:0] sum;
    logic [21:0] r;
    logic [15:0] mag;
    sum = p + (64'd1 << 41);
    r   = sum[63:42];
    if (neg) begin
      mag = (r > 22'd32768) ? 16'd32768 : r[15:0];
      return ~mag + 16'd1;
    end
    return (r > 22'd32767) ? 16'd32767 : r[15:0];
  endfunction

  // input capture
  assign freq_raw = in_data.freq_offset;
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      freq_neg_r <= freq_raw[23];
      freq_mag_r <= freq_raw[23] ? (~freq_raw + 24'd1) : freq_raw;
      dist_r     <= cfg.spatial_enable ? in_data.distance_gain : ddsosc_pkg::DIST_ONE;
      ang_r      <= in_data.pan_angle;
    end
  end

  // phase accumulator, floor of the signed offset product over 2^16
  assign prod_neg    = ~prod_r[47:0] + 48'd1;
  assign step_offset = !cfg.fm_enable ? 32'd0 :
                       (freq_neg_r ? prod_neg[47:16] : prod_r[47:16]);
  assign phase_nxt   = phase_r + cfg.base_increment + step_offset;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (cmd.phase_upd) begin
      phase_r <= phase_nxt;
    end
  end

  // quarter-wave table address and quadrant
  always_comb begin
    case (cmd.rom_sel)
      ddsosc_pkg::ROM_ANG:   lookup_ph = {ang_r, 16'd0};
      ddsosc_pkg::ROM_ANG_Q: lookup_ph = {ang_r, 16'd0} + ddsosc_pkg::QUARTER_TURN;
      ddsosc_pkg::ROM_PHASE: lookup_ph = phase_r;
      default:               lookup_ph = phase_r;
    endcase
  end

  assign lookup_idx  = IW'((64'(lookup_ph) * 64'(4 * ddsosc_pkg::SINE_DEPTH)) >> 32);
  assign lookup_quad = 2'(lookup_idx / ddsosc_pkg::SINE_DEPTH);
  assign lookup_off  = AW'(lookup_idx % ddsosc_pkg::SINE_DEPTH);
  assign rom_addr    = lookup_quad[0] ? (AW'(ddsosc_pkg::SINE_DEPTH) - lookup_off)
                                      : lookup_off;

  // registered table read
  always_ff @(posedge clk) begin
    rom_q_r   <= ddsosc_pkg::SINE_ROM[rom_addr];
    rom_neg_r <= lookup_quad[1];
  end

  // shared multiplier operands
  always_comb begin
    case (cmd.mul_sel)
      ddsosc_pkg::MUL_FM: begin
        mul_a = {8'd0, freq_mag_r};
        mul_b = cfg.hz_to_phase_gain;
      end
      ddsosc_pkg::MUL_SQ: begin
        mul_a = {16'd0, rom_q_r};
        mul_b = {16'd0, rom_q_r};
      end
      ddsosc_pkg::MUL_AMP: begin
        mul_a = {16'd0, rom_q_r};
        mul_b = {16'd0, cfg.amplitude};
      end
      ddsosc_pkg::MUL_DIST_A: begin
        mul_a = {16'd0, dist_r};
        mul_b = {16'd0, pan_a_r};
      end
      ddsosc_pkg::MUL_DIST_B: begin
        mul_a = {16'd0, dist_r};
        mul_b = {16'd0, pan_b_r};
      end
      ddsosc_pkg::MUL_OUT_A: begin
        mul_a = p1_r;
        mul_b = qa_r;
      end
      ddsosc_pkg::MUL_OUT_B: begin
        mul_a = p1_r;
        mul_b = qb_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_sel != ddsosc_pkg::MUL_NONE) begin
      prod_r <= 64'(mul_a) * 64'(mul_b);
    end
  end

  // pan gain from the squared sine, Q1.15
  assign pan_val = 16'((prod_r[31:0] + 32'd16384) >> 15);

  always_ff @(posedge clk) begin
    if (cmd.pan_a_ld) begin
      pan_a_r <= cfg.spatial_enable ? pan_val : ddsosc_pkg::PAN_ONE;
    end
    if (cmd.pan_b_ld) begin
      pan_b_r <= cfg.spatial_enable ? pan_val : ddsosc_pkg::PAN_ONE;
    end
    if (cmd.sign_ld) begin
      sign_r <= rom_neg_r;
    end
    if (cmd.p1_ld) begin
      p1_r <= prod_r[31:0];
    end
    if (cmd.qa_ld) begin
      qa_r <= prod_r[31:0];
    end
    if (cmd.qb_ld) begin
      qb_r <= prod_r[31:0];
    end
    if (cmd.res_a_ld) begin
      res_a_r <= round_sat(prod_r, sign_r);
    end
  end

  // output register
  assign res_b = round_sat(prod_r, sign_r);

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_data_r.sample_first <= res_a_r;
      out_data_r.sample_other <= res_b;
    end
  end

  assign out_data = out_data_r;

endmodule

// ===== rtl/core/dds_sine_oscillator_with_pan_top.sv =====
// Sine oscillator with distance gain and two-channel pan.
// Input channel (in_valid/in_ready/in_data): one transaction per frame tick,
// carrying a frequency offset, a distance gain and a pan angle. Output
// channel (out_valid/out_ready/out_data): one transaction per input, the
// first channel sample (sin^2 pan) and the other channel sample (cos^2 pan).
// Configuration: cfg_we writes cfg_wdata to the register at cfg_index
// (base increment, hz-to-phase gain, amplitude, fm enable, spatial enable);
// write only while the block is idle.
// Sequence: an accepted input steps the sequencer through FM, PH, PA, PB,
// DA, DB, OA, OB and DONE, which loads the output register and out_valid.
// A new input waits for idle; the shared 32x32 multiplier and sine table
// read port, one of each, serve eight multiplies and three table reads.
// Reset: phase is cleared, amplitude returns to 1.0, other config and out_valid to 0.
// Stall: the result sits in an output register; while it is not taken the
// next input is still accepted and computed, then waits for the slot.
module dds_sine_oscillator_with_pan_top (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  ddsosc_pkg::in_item_t   in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output ddsosc_pkg::out_item_t  out_data,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [31:0]            cfg_wdata
);

  ddsosc_pkg::cfg_t cfg;
  ddsosc_pkg::cmd_t cmd;

  ddsosc_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ddsosc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  ddsosc_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

// ===== rtl/core/ddsosc_checker.sv =====
module ddsosc_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input ddsosc_pkg::out_item_t  out_data
);

  // one item at a time: no new input right after a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in progress");

  // the sequence keeps the input closed until the result is ready
  a_busy_span: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##9 !in_ready)
    else $error("input reopened before the sequence finished");

  // a new result only appears at the end of a sequence
  a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while the block was idle");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output transaction changed");

endmodule

bind dds_sine_oscillator_with_pan_top ddsosc_checker u_checker (.*);
